### src/tcp_pkg.sv
package tcp_pkg;

  // table geometry and config store size
  localparam int TABLE_SIDE   = 16;
  localparam int CONFIG_BYTES = 128;
  localparam int CELL_COUNT   = TABLE_SIDE * TABLE_SIDE;
  localparam int BIN_COUNT    = 2 * TABLE_SIDE;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 9;
  localparam int OUT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // page number held before any page command
  localparam logic [BYTE_W-1:0] NO_PAGE = 8'hFF;

  // command letters
  localparam logic [BYTE_W-1:0] CMD_PAGE      = 8'h50; // 'P'
  localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'h57; // 'W'
  localparam logic [BYTE_W-1:0] CMD_REALTIME  = 8'h41; // 'A'
  localparam logic [BYTE_W-1:0] CMD_BURN      = 8'h42; // 'B'
  localparam logic [BYTE_W-1:0] CMD_SEND_PAGE = 8'h56; // 'V'
  localparam logic [BYTE_W-1:0] CMD_SIGNATURE = 8'h53; // 'S'
  localparam logic [BYTE_W-1:0] CMD_VERSION   = 8'h51; // 'Q'
  localparam logic [BYTE_W-1:0] CMD_C         = 8'h43; // 'C'
  localparam logic [BYTE_W-1:0] CMD_F         = 8'h46; // 'F'
  localparam logic [BYTE_W-1:0] CMD_CALIBRATE = 8'h74; // 't'
  localparam logic [BYTE_W-1:0] CMD_DEBUG     = 8'h44; // 'D'

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FUEL_PAGE,
    REG_CFG_PAGE,
    REG_IGNITION_PAGE,
    REG_MIXTURE_PAGE
  } reg_index_t;

  // page register reset values
  localparam logic [BYTE_W-1:0] FUEL_PAGE_RESET     = 8'd1;
  localparam logic [BYTE_W-1:0] CFG_PAGE_RESET      = 8'd2;
  localparam logic [BYTE_W-1:0] IGNITION_PAGE_RESET = 8'd3;
  localparam logic [BYTE_W-1:0] MIXTURE_PAGE_RESET  = 8'd5;

  typedef enum logic [3:0] {
    EV_REALTIME,
    EV_BURN,
    EV_SEND_PAGE,
    EV_SIGNATURE,
    EV_VERSION,
    EV_C,
    EV_F,
    EV_CALIBRATE,
    EV_DEBUG,
    EV_WRITE_DONE
  } event_t;

  typedef enum logic [2:0] {
    SEL_FUEL,
    SEL_IGNITION,
    SEL_MIXTURE,
    SEL_CONFIG,
    SEL_NONE
  } store_sel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] fuel;
    logic [BYTE_W-1:0] cfg_page;
    logic [BYTE_W-1:0] ignition;
    logic [BYTE_W-1:0] mixture;
  } page_map_t;

  typedef struct packed {
    logic [BYTE_W-1:0] current_page;
    logic              page_pending;
    logic              write_active;
    logic [1:0]        offset_stage;
    logic [BYTE_W-1:0] offset_low;
    logic [BYTE_W-1:0] offset_high;
  } parser_state_t;

  typedef struct packed {
    event_t            event_code;
    logic [BYTE_W-1:0] page_now;
    store_sel_t        store_select;
    logic [ADDR_W-1:0] store_address;
    logic [BYTE_W-1:0] store_data;
  } result_t;

endpackage

### src/tcp_cfg_regs.sv
module tcp_cfg_regs
  import tcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output page_map_t          pages
);

  reg_index_t reg_index;
  logic       wr_en;
  logic [BYTE_W-1:0] rd_byte;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[PADDR_W-1:2]);
  assign wr_en     = psel && penable && pwrite && pready;

  // page number registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pages.fuel     <= FUEL_PAGE_RESET;
      pages.cfg_page <= CFG_PAGE_RESET;
      pages.ignition <= IGNITION_PAGE_RESET;
      pages.mixture  <= MIXTURE_PAGE_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_FUEL_PAGE:     pages.fuel     <= pwdata[BYTE_W-1:0];
        REG_CFG_PAGE:      pages.cfg_page <= pwdata[BYTE_W-1:0];
        REG_IGNITION_PAGE: pages.ignition <= pwdata[BYTE_W-1:0];
        REG_MIXTURE_PAGE:  pages.mixture  <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_index)
      REG_FUEL_PAGE:     rd_byte = pages.fuel;
      REG_CFG_PAGE:      rd_byte = pages.cfg_page;
      REG_IGNITION_PAGE: rd_byte = pages.ignition;
      REG_MIXTURE_PAGE:  rd_byte = pages.mixture;
      default:           rd_byte = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-BYTE_W){1'b0}}, rd_byte};

endmodule

### src/tcp_decode.sv
module tcp_decode
  import tcp_pkg::*;
(
  input  parser_state_t     st,
  input  page_map_t         pages,
  input  logic [BYTE_W-1:0] rx_byte,
  output parser_state_t     st_next,
  output logic              emit,
  output result_t           res
);

  typedef enum logic [2:0] {
    CLS_FUEL,
    CLS_CONFIG,
    CLS_IGN,
    CLS_MIX,
    CLS_OTHER
  } page_class_t;

  localparam logic [ADDR_W-1:0] CFG_LIMIT = ADDR_W'(CONFIG_BYTES);
  localparam logic [ADDR_W-1:0] BIN_BASE  = ADDR_W'(CELL_COUNT);
  localparam logic [BYTE_W-1:0] BIN_LIMIT = BYTE_W'(BIN_COUNT);

  page_class_t cls;
  logic        is_table;
  store_sel_t  table_sel;

  // page class, first match wins when page numbers coincide
  always_comb begin
    if (st.current_page == pages.fuel) begin
      cls = CLS_FUEL;
    end else if (st.current_page == pages.cfg_page) begin
      cls = CLS_CONFIG;
    end else if (st.current_page == pages.ignition) begin
      cls = CLS_IGN;
    end else if (st.current_page == pages.mixture) begin
      cls = CLS_MIX;
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_comb begin
    case (cls)
      CLS_FUEL: table_sel = SEL_FUEL;
      CLS_IGN:  table_sel = SEL_IGNITION;
      CLS_MIX:  table_sel = SEL_MIXTURE;
      default:  table_sel = SEL_NONE;
    endcase
  end

  assign is_table = (table_sel != SEL_NONE);

  // next parser state and result of this byte
  always_comb begin
    st_next           = st;
    emit              = 1'b0;
    res.event_code    = EV_WRITE_DONE;
    res.page_now      = st.current_page;
    res.store_select  = SEL_NONE;
    res.store_address = '0;
    res.store_data    = '0;

    if (st.page_pending) begin
      st_next.current_page = rx_byte;
      st_next.page_pending = 1'b0;
    end else if (st.write_active) begin
      if (st.offset_stage == 2'd0) begin
        st_next.offset_low   = rx_byte;
        st_next.offset_stage = 2'd1;
      end else if (is_table && st.offset_stage == 2'd1) begin
        st_next.offset_high  = rx_byte;
        st_next.offset_stage = 2'd2;
      end else begin
        // data byte ends the write
        emit = 1'b1;
        if (cls == CLS_CONFIG) begin
          if ({1'b0, st.offset_low} < CFG_LIMIT) begin
            res.store_select  = SEL_CONFIG;
            res.store_address = {1'b0, st.offset_low};
            res.store_data    = rx_byte;
          end
        end else if (is_table) begin
          if (st.offset_high == '0) begin
            // cell: row nibble above column nibble
            res.store_select  = table_sel;
            res.store_address = {1'b0, st.offset_low[7:4], st.offset_low[3:0]};
            res.store_data    = rx_byte;
          end else if (st.offset_low < BIN_LIMIT) begin
            res.store_select  = table_sel;
            res.store_address = BIN_BASE + {1'b0, st.offset_low};
            res.store_data    = rx_byte;
          end
        end
        st_next.offset_low   = '0;
        st_next.offset_high  = '0;
        st_next.offset_stage = 2'd0;
        st_next.write_active = 1'b0;
      end
    end else begin
      emit = 1'b1;
      case (rx_byte)
        CMD_REALTIME:  res.event_code = EV_REALTIME;
        CMD_BURN:      res.event_code = EV_BURN;
        CMD_SEND_PAGE: res.event_code = EV_SEND_PAGE;
        CMD_SIGNATURE: res.event_code = EV_SIGNATURE;
        CMD_VERSION:   res.event_code = EV_VERSION;
        CMD_C:         res.event_code = EV_C;
        CMD_F:         res.event_code = EV_F;
        CMD_CALIBRATE: res.event_code = EV_CALIBRATE;
        CMD_DEBUG:     res.event_code = EV_DEBUG;
        CMD_PAGE: begin
          emit                 = 1'b0;
          st_next.page_pending = 1'b1;
        end
        CMD_WRITE: begin
          emit                 = 1'b0;
          st_next.write_active = 1'b1;
        end
        default: emit = 1'b0;
      endcase
    end
  end

endmodule

### src/tuning_command_parser.sv
// Serial command parser for an engine-tuning link. Each received byte on the
// s_ side is parsed by combinational decode logic: 'P' takes the next byte as the current page,
// 'W' takes one or two offset bytes and a data byte and ends in a write-done
// transaction carrying the target store, address and data, which the
// surrounding design applies to its own fuel, ignition, mixture and config
// stores; other command letters give request transactions. Sustained rate is
// one byte per clock: the parser state registers feed one stage of decode
// logic into the output register, and s_tready drops only while that output
// register holds a result that m_tready has not yet taken. A result appears on
// m_ in the cycle after the byte that causes it is accepted. The page numbers that select
// each store are set through the APB port.
module tuning_command_parser
  import tcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input byte stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // [3:0] event_code, [11:4] page_now,
                                        // [14:12] store_select,
                                        // [23:15] store_address, [31:24] store_data
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  page_map_t     pages;
  parser_state_t st;
  parser_state_t st_next;
  logic          emit;
  result_t       res;
  result_t       out_res;
  logic          s_accept;

  tcp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pages   (pages)
  );

  tcp_decode u_decode (
    .st      (st),
    .pages   (pages),
    .rx_byte (s_tdata),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.current_page <= NO_PAGE;
      st.page_pending <= 1'b0;
      st.write_active <= 1'b0;
      st.offset_stage <= 2'd0;
      st.offset_low   <= '0;
      st.offset_high  <= '0;
    end else if (s_accept) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && emit) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.store_data, out_res.store_address, out_res.store_select,
                    out_res.page_now, out_res.event_code};

  // checks on the parser
  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.store_select == SEL_NONE
      |-> out_res.store_address == '0 && out_res.store_data == '0)
    else $error("store address or data set with no store selected");

  a_store_only_on_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.event_code != EV_WRITE_DONE |-> out_res.store_select == SEL_NONE)
    else $error("store selected on a request transaction");

  a_page_taken: assert property (@(posedge clk) disable iff (rst)
    s_accept && st.page_pending
      |=> st.current_page == $past(s_tdata) && !st.page_pending && !st.write_active)
    else $error("page argument not taken as current page");

  a_stage_in_write: assert property (@(posedge clk) disable iff (rst)
    st.offset_stage != 2'd0 |-> st.write_active && st.offset_stage != 2'd3)
    else $error("offset stage outside a write");

  a_no_mode_overlap: assert property (@(posedge clk) disable iff (rst)
    !(st.page_pending && st.write_active))
    else $error("page argument and write both pending");

endmodule

### verif/tuning_command_checker.sv
`timescale 1ns / 100ps

// watches the byte, result and register channels of the command parser,
// predicts every result from the accepted bytes and compares in order
module tuning_command_checker
  import tcp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [OUT_W-1:0]   m_tdata,   // [3:0] event_code, [11:4] page_now,
                                        // [14:12] store_select,
                                        // [23:15] store_address, [31:24] store_data
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked,
  output int                 stores_written
);

  typedef enum {
    CLASS_FUEL,
    CLASS_CONFIG,
    CLASS_IGNITION,
    CLASS_MIXTURE,
    CLASS_OTHER
  } page_class_t;

  page_map_t     page_map;
  parser_state_t parser;
  result_t       expected_results[$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    stores_written  = 0;
  end

  // page decode, fuel first, then config, ignition, mixture
  function automatic page_class_t classify_page(input logic [7:0] page);
    if (page == page_map.fuel) return CLASS_FUEL;
    if (page == page_map.cfg_page) return CLASS_CONFIG;
    if (page == page_map.ignition) return CLASS_IGNITION;
    if (page == page_map.mixture) return CLASS_MIXTURE;
    return CLASS_OTHER;
  endfunction

  // write completion: target store, address and data of a write-done event
  function automatic result_t finish_write(input logic [7:0] data);
    result_t     r;
    page_class_t cls;
    int          addr;
    r.event_code    = EV_WRITE_DONE;
    r.page_now      = parser.current_page;
    r.store_select  = SEL_NONE;
    r.store_address = '0;
    r.store_data    = '0;
    cls = classify_page(parser.current_page);
    addr = -1;
    case (cls)
      CLASS_CONFIG: begin
        if (parser.offset_low < CONFIG_BYTES) addr = int'(parser.offset_low);
      end
      CLASS_FUEL, CLASS_IGNITION, CLASS_MIXTURE: begin
        // cell from the offset nibbles, or an axis bin after the cells
        if (parser.offset_high == 8'd0)
          addr = int'(parser.offset_low[7:4]) * TABLE_SIDE + int'(parser.offset_low[3:0]);
        else if (parser.offset_low < BIN_COUNT)
          addr = CELL_COUNT + int'(parser.offset_low);
      end
      default: addr = -1;
    endcase
    if (addr >= 0) begin
      case (cls)
        CLASS_FUEL:     r.store_select = SEL_FUEL;
        CLASS_IGNITION: r.store_select = SEL_IGNITION;
        CLASS_MIXTURE:  r.store_select = SEL_MIXTURE;
        default:        r.store_select = SEL_CONFIG;
      endcase
      r.store_address = ADDR_W'(addr);
      r.store_data    = data;
    end
    return r;
  endfunction

  // one received byte through the parser state
  task automatic parse_rx_byte(input logic [7:0] b);
    result_t     r;
    page_class_t cls;
    logic        raise;
    logic        two_offsets;
    event_t      ev;
    raise = 1'b0;
    ev    = EV_REALTIME;
    if (parser.page_pending) begin
      parser.current_page = b;
      parser.page_pending = 1'b0;
    end else if (parser.write_active) begin
      cls = classify_page(parser.current_page);
      two_offsets = (cls == CLASS_FUEL) || (cls == CLASS_IGNITION) || (cls == CLASS_MIXTURE);
      if (parser.offset_stage == 2'd0) begin
        parser.offset_low   = b;
        parser.offset_stage = 2'd1;
      end else if (two_offsets && parser.offset_stage == 2'd1) begin
        parser.offset_high  = b;
        parser.offset_stage = 2'd2;
      end else begin
        r = finish_write(b);
        expected_results.push_back(r);
        parser.offset_low   = '0;
        parser.offset_high  = '0;
        parser.offset_stage = 2'd0;
        parser.write_active = 1'b0;
      end
    end else begin
      raise = 1'b1;
      case (b)
        CMD_REALTIME:  ev = EV_REALTIME;
        CMD_BURN:      ev = EV_BURN;
        CMD_SEND_PAGE: ev = EV_SEND_PAGE;
        CMD_SIGNATURE: ev = EV_SIGNATURE;
        CMD_VERSION:   ev = EV_VERSION;
        CMD_C:         ev = EV_C;
        CMD_F:         ev = EV_F;
        CMD_CALIBRATE: ev = EV_CALIBRATE;
        CMD_DEBUG:     ev = EV_DEBUG;
        CMD_PAGE: begin
          parser.page_pending = 1'b1;
          raise = 1'b0;
        end
        CMD_WRITE: begin
          parser.write_active = 1'b1;
          raise = 1'b0;
        end
        default: raise = 1'b0;
      endcase
      if (raise) begin
        r.event_code    = ev;
        r.page_now      = parser.current_page;
        r.store_select  = SEL_NONE;
        r.store_address = '0;
        r.store_data    = '0;
        expected_results.push_back(r);
      end
    end
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result(input logic [OUT_W-1:0] word);
    result_t exp;
    logic    bad;
    results_checked++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result ev %0d page %0d sel %0d addr %0d data %0d",
                 $realtime, word[3:0], word[11:4], word[14:12], word[23:15], word[31:24]);
    end else begin
      exp = expected_results.pop_front();
      bad = (word[3:0] !== exp.event_code) || (word[11:4] !== exp.page_now) ||
            (word[14:12] !== exp.store_select) || (word[23:15] !== exp.store_address) ||
            (word[31:24] !== exp.store_data);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected ev %0d page %0d sel %0d addr %0d data %0d",
                   exp.event_code, exp.page_now, exp.store_select,
                   exp.store_address, exp.store_data);
          $display("  actual   ev %0d page %0d sel %0d addr %0d data %0d",
                   word[3:0], word[11:4], word[14:12], word[23:15], word[31:24]);
        end
      end else if (exp.store_select != SEL_NONE) begin
        stores_written++;
      end
    end
  endtask

  // results first, as they belong to bytes taken on earlier edges
  always @(posedge clk) begin
    if (rst) begin
      page_map.fuel       = FUEL_PAGE_RESET;
      page_map.cfg_page   = CFG_PAGE_RESET;
      page_map.ignition   = IGNITION_PAGE_RESET;
      page_map.mixture    = MIXTURE_PAGE_RESET;
      parser.current_page = NO_PAGE;
      parser.page_pending = 1'b0;
      parser.write_active = 1'b0;
      parser.offset_stage = 2'd0;
      parser.offset_low   = '0;
      parser.offset_high  = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_FUEL_PAGE:     page_map.fuel     = pwdata[7:0];
          REG_CFG_PAGE:      page_map.cfg_page = pwdata[7:0];
          REG_IGNITION_PAGE: page_map.ignition = pwdata[7:0];
          default:           page_map.mixture  = pwdata[7:0];
        endcase
      end
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
    end
    outstanding = expected_results.size();
  end

endmodule

### verif/tb_tuning_command_parser.sv
`timescale 1ns / 100ps

module tb_tuning_command_parser;
  import tcp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int BYTES_PER_PHASE  = 228;
  localparam int PHASE_COUNT      = 7;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;   // [7:0] rx_byte
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;         // [3:0] event_code, [11:4] page_now,
                                       // [14:12] store_select,
                                       // [23:15] store_address, [31:24] store_data
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int results_checked;
  int stores_written;

  // stimulus-side view of the page map and the page last selected
  logic [7:0] page_reg [4];
  logic [7:0] stim_page;
  bit         steady      = 1'b0;
  int         stall_left  = 0;
  int         bytes_sent  = 0;
  int         maps_used   = 0;
  int         idle_cycles = 0;
  int         phase_start = 0;

  tuning_command_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tuning_command_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .stores_written  (stores_written)
  );

  always #10 clk = ~clk;

  // result side back-pressure: mostly short stalls, a few long ones
  initial begin
    forever begin
      @(negedge clk);
      if (steady || stall_left == 0) begin
        m_tready <= 1'b1;
        if (!steady) begin
          case ($urandom_range(0, 99)) inside
            [0:19]:  stall_left = $urandom_range(1, 3);
            [20:21]: stall_left = $urandom_range(12, 40);
            default: stall_left = 0;
          endcase
        end
      end else begin
        m_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // no transaction of any kind for too long ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 99)) inside
      [0:59]:  return 0;
      [60:93]: return $urandom_range(1, 3);
      default: return $urandom_range(8, 40);
    endcase
  endfunction

  // request letters first, then letters and bytes the parser ignores
  function automatic logic [7:0] request_letter(input int i);
    case (i)
      0:       return CMD_REALTIME;
      1:       return CMD_BURN;
      2:       return CMD_SEND_PAGE;
      3:       return CMD_SIGNATURE;
      4:       return CMD_VERSION;
      5:       return CMD_C;
      6:       return CMD_F;
      7:       return CMD_CALIBRATE;
      8:       return CMD_DEBUG;
      9:       return "L";
      10:      return "N";
      11:      return "R";
      12:      return "T";
      13:      return "r";
      default: return "?";
    endcase
  endfunction

  function automatic logic takes_two_offsets(input logic [7:0] page);
    if (page == page_reg[REG_FUEL_PAGE]) return 1'b1;
    if (page == page_reg[REG_CFG_PAGE]) return 1'b0;
    return (page == page_reg[REG_IGNITION_PAGE]) || (page == page_reg[REG_MIXTURE_PAGE]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic select_page(input logic [7:0] page);
    send_byte(CMD_PAGE);
    send_byte(page);
    stim_page = page;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_page_register(input reg_index_t idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    page_reg[idx] = value;
  endtask

  task automatic program_page_map(input int phase);
    logic [7:0] pages [4];
    case (phase)
      1: pages = '{8'd0, 8'd255, 8'd128, 8'd127};   // extremes
      2: pages = '{8'd42, 8'd42, 8'd42, 8'd42};     // all equal, fuel wins
      3: pages = '{8'd9, 8'd4, 8'd4, 8'd9};         // config over ignition
      4: pages = '{8'd255, 8'd0, 8'd119, 8'd119};   // ignition over mixture
      5: pages = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      default: pages = '{FUEL_PAGE_RESET, CFG_PAGE_RESET,
                         IGNITION_PAGE_RESET, MIXTURE_PAGE_RESET};
    endcase
    write_page_register(REG_FUEL_PAGE, pages[0]);
    write_page_register(REG_CFG_PAGE, pages[1]);
    write_page_register(REG_IGNITION_PAGE, pages[2]);
    write_page_register(REG_MIXTURE_PAGE, pages[3]);
    maps_used++;
  endtask

  // a write command with offsets and data matched to the current page
  task automatic send_write();
    logic [7:0] low;
    logic [7:0] high;
    send_byte(CMD_WRITE);
    if (takes_two_offsets(stim_page)) begin
      if ($urandom_range(0, 1) == 0) begin
        low  = 8'($urandom_range(0, 255));
        high = 8'd0;
      end else begin
        high = 8'($urandom_range(1, 255));
        low  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, BIN_COUNT - 1));
      end
      send_byte(low);
      send_byte(high);
    end else begin
      if (stim_page == page_reg[REG_CFG_PAGE] && $urandom_range(0, 4) != 0)
        low = 8'($urandom_range(0, CONFIG_BYTES - 1));
      else
        low = 8'($urandom_range(0, 255));
      send_byte(low);
    end
    send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_sequence();
    logic [7:0] b;
    int         args;
    int         pos;
    case ($urandom_range(0, 99)) inside
      [0:24]: begin
        case ($urandom_range(0, 6))
          0:       select_page(page_reg[REG_FUEL_PAGE]);
          1:       select_page(page_reg[REG_CFG_PAGE]);
          2:       select_page(page_reg[REG_IGNITION_PAGE]);
          3:       select_page(page_reg[REG_MIXTURE_PAGE]);
          4:       select_page(NO_PAGE);
          5:       select_page(8'd0);
          default: select_page(8'($urandom_range(0, 255)));
        endcase
      end
      [25:64]: send_write();
      [65:84]: send_byte(request_letter($urandom_range(0, 14)));
      [85:92]: begin
        // noise byte, never a page or write command
        b = 8'($urandom_range(0, 255));
        if (b == CMD_PAGE || b == CMD_WRITE) b = b ^ 8'h80;
        send_byte(b);
      end
      default: begin
        // a command letter where an argument is due
        if ($urandom_range(0, 1) == 0) begin
          select_page(request_letter($urandom_range(0, 14)));
        end else begin
          args = takes_two_offsets(stim_page) ? 3 : 2;
          pos  = $urandom_range(0, args - 1);
          send_byte(CMD_WRITE);
          for (int k = 0; k < args; k++)
            send_byte((k == pos) ? request_letter($urandom_range(0, 14))
                                 : 8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  initial begin
    page_reg[REG_FUEL_PAGE]     = FUEL_PAGE_RESET;
    page_reg[REG_CFG_PAGE]      = CFG_PAGE_RESET;
    page_reg[REG_IGNITION_PAGE] = IGNITION_PAGE_RESET;
    page_reg[REG_MIXTURE_PAGE]  = MIXTURE_PAGE_RESET;
    stim_page = NO_PAGE;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every letter before any page, then one write of each kind
    for (int i = 0; i < 15; i++) send_byte(request_letter(i));
    select_page(page_reg[REG_FUEL_PAGE]);
    send_write();
    send_byte(CMD_WRITE); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAB);
    send_byte(CMD_WRITE); send_byte(8'h1F); send_byte(8'h01); send_byte(8'h00);
    send_byte(CMD_WRITE); send_byte(8'h20); send_byte(8'h80); send_byte(8'h55);
    select_page(page_reg[REG_CFG_PAGE]);
    send_byte(CMD_WRITE); send_byte(8'h7F); send_byte(8'hFF);
    send_byte(CMD_WRITE); send_byte(8'h80); send_byte(8'h12);
    // unassigned page, with letters taken as arguments
    select_page(CMD_WRITE);
    send_byte(CMD_WRITE); send_byte(CMD_REALTIME); send_byte(CMD_BURN);
    send_byte(CMD_SIGNATURE);

    // random phases, one page map each
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      program_page_map(phase);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        steady = (phase % 2 == 1) && (bytes_sent - phase_start < 60);
        if ($urandom_range(0, 99) == 0) drain_results();
        send_random_sequence();
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (10) @(negedge clk);
    $display("sent %0d bytes under %0d page maps, letters, pages and writes of every kind",
             bytes_sent, maps_used);
    $display("checked %0d results, %0d of them writes into a store",
             results_checked, stores_written);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
src/tcp_pkg.sv
src/tcp_cfg_regs.sv
src/tcp_decode.sv
src/tuning_command_parser.sv
verif/tuning_command_checker.sv
verif/tb_tuning_command_parser.sv
